[rtl/smis_pkg.sv]
package smis_pkg;

  localparam int unsigned DATA_DEPTH_DEF = 32;
  localparam int unsigned CALL_DEPTH_DEF = 32;
  localparam int unsigned WORD_BITS_DEF  = 32;

  localparam logic [7:0] OP_PUSH  = 8'd0;
  localparam logic [7:0] OP_ADD   = 8'd1;
  localparam logic [7:0] OP_SUB   = 8'd2;
  localparam logic [7:0] OP_ROT   = 8'd3;
  localparam logic [7:0] OP_DUP   = 8'd4;
  localparam logic [7:0] OP_DROP  = 8'd5;
  localparam logic [7:0] OP_CALL  = 8'd6;
  localparam logic [7:0] OP_IFNEQ = 8'd7;
  localparam logic [7:0] OP_RET   = 8'd8;
  localparam logic [7:0] OP_HALT  = 8'd9;

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_DOVF = 3'd2;
  localparam logic [2:0] ST_DUNF = 3'd3;
  localparam logic [2:0] ST_COVF = 3'd4;
  localparam logic [2:0] ST_CUNF = 3'd5;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DOWN,
    CELL_UP1,
    CELL_UP2
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd0;
    cell_cmd_t cmd1;
    cell_cmd_t cmd_rest;
  } stk_ctrl_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         next_address;
    logic signed [31:0] top_value;
    logic [5:0]         stack_depth;
    logic [2:0]         status;
  } out_item_t;

endpackage

[rtl/smis_cell.sv]
module smis_cell #(
  parameter int unsigned Width = 8
) (
  input  logic                clk,
  input  smis_pkg::cell_cmd_t cmd,
  input  logic [Width-1:0]    from_above,
  input  logic [Width-1:0]    from_below,
  input  logic [Width-1:0]    from_below2,
  input  logic [Width-1:0]    load,
  output logic [Width-1:0]    value
);

  always_ff @(posedge clk) begin
    case (cmd)
      smis_pkg::CELL_LOAD: value <= load;
      smis_pkg::CELL_DOWN: value <= from_above;
      smis_pkg::CELL_UP1:  value <= from_below;
      smis_pkg::CELL_UP2:  value <= from_below2;
      default:             value <= value;
    endcase
  end

endmodule

[rtl/smis_stack.sv]
module smis_stack #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                clk,
  input  smis_pkg::stk_ctrl_t ctrl,
  input  logic [Width-1:0]    load0,
  input  logic [Width-1:0]    load1,
  output logic [Width-1:0]    top0,
  output logic [Width-1:0]    top1
);

  logic [Width-1:0] q [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [Width-1:0]    above_v;
    logic [Width-1:0]    below_v;
    logic [Width-1:0]    below2_v;
    logic [Width-1:0]    load_v;
    smis_pkg::cell_cmd_t c;

    if (i == 0) begin : g_first
      assign above_v = '0;
      assign c       = ctrl.cmd0;
      assign load_v  = load0;
    end else if (i == 1) begin : g_second
      assign above_v = q[i-1];
      assign c       = ctrl.cmd1;
      assign load_v  = load1;
    end else begin : g_rest
      assign above_v = q[i-1];
      assign c       = ctrl.cmd_rest;
      assign load_v  = '0;
    end

    if (i + 1 < Depth) begin : g_b1
      assign below_v = q[i+1];
    end else begin : g_b1_end
      assign below_v = '0;
    end

    if (i + 2 < Depth) begin : g_b2
      assign below2_v = q[i+2];
    end else begin : g_b2_end
      assign below2_v = '0;
    end

    smis_cell #(.Width(Width)) u_cell (
      .clk         (clk),
      .cmd         (c),
      .from_above  (above_v),
      .from_below  (below_v),
      .from_below2 (below2_v),
      .load        (load_v),
      .value       (q[i])
    );
  end

  assign top0 = q[0];

  if (Depth > 1) begin : g_top1
    assign top1 = q[1];
  end else begin : g_top1_none
    assign top1 = '0;
  end

endmodule

[rtl/stack_machine_instruction_step_unit.sv]
// Channel | Direction | Handshake             | Payload
// cmd     | in        | cmd_valid / cmd_ready | in_item_t  (opcode, operand)
// res     | out       | res_valid / res_ready | out_item_t (next_address, top_value,
//         |           |                       |             stack_depth, status)
// One item per cycle: every instruction touches only the two top cells of each
// stack, and all cells of a chain shift together in the cycle the item is taken.
// The result shows in the cycle after its item is taken, from registered state.
// cmd_ready drops only while a result waits and res_ready is low.
// Synchronous reset empties both stacks, clears pc and halt; cells need no clear.
module stack_machine_instruction_step_unit #(
  parameter int unsigned DataDepth = smis_pkg::DATA_DEPTH_DEF,
  parameter int unsigned CallDepth = smis_pkg::CALL_DEPTH_DEF,
  parameter int unsigned WordBits  = smis_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  smis_pkg::in_item_t   cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output smis_pkg::out_item_t  res
);

  localparam int unsigned DW = $clog2(DataDepth + 1);
  localparam int unsigned RW = $clog2(CallDepth + 1);

  logic [DW-1:0] data_count, data_count_next;
  logic [RW-1:0] return_count, return_count_next;
  logic [7:0]    pc, pc_next;
  logic          halted, halted_next;
  logic [2:0]    status, status_next;
  logic          step;

  smis_pkg::stk_ctrl_t dctl, dctl_op;
  smis_pkg::stk_ctrl_t rctl, rctl_op;
  logic [WordBits-1:0] dload0, dload1, dtop0, dtop1;
  logic [7:0]          rload0, rtop0;

  localparam smis_pkg::stk_ctrl_t CtlHold =
    '{smis_pkg::CELL_HOLD, smis_pkg::CELL_HOLD, smis_pkg::CELL_HOLD};
  localparam smis_pkg::stk_ctrl_t CtlPush =
    '{smis_pkg::CELL_LOAD, smis_pkg::CELL_DOWN, smis_pkg::CELL_DOWN};
  localparam smis_pkg::stk_ctrl_t CtlPop =
    '{smis_pkg::CELL_UP1, smis_pkg::CELL_UP1, smis_pkg::CELL_UP1};

  assign cmd_ready = !res_valid || res_ready;
  assign step      = cmd_valid && cmd_ready;

  always_comb begin
    dctl_op           = CtlHold;
    rctl_op           = CtlHold;
    dload0            = dtop0;
    dload1            = dtop0;
    rload0            = 8'(pc + 8'd2);
    data_count_next   = data_count;
    return_count_next = return_count;
    pc_next           = pc;
    halted_next       = halted;
    status_next       = smis_pkg::ST_RUN;
    if (halted) begin
      status_next = smis_pkg::ST_HALT;
    end else begin
      case (cmd.opcode)
        smis_pkg::OP_PUSH: begin
          if (data_count == DW'(DataDepth)) begin
            status_next = smis_pkg::ST_DOVF;
          end else begin
            dctl_op         = CtlPush;
            dload0          = WordBits'($signed(cmd.operand));
            data_count_next = data_count + DW'(1);
            pc_next         = pc + 8'd2;
          end
        end
        smis_pkg::OP_ADD, smis_pkg::OP_SUB: begin
          if (data_count < DW'(2)) begin
            status_next = smis_pkg::ST_DUNF;
          end else begin
            dctl_op         = '{smis_pkg::CELL_LOAD, smis_pkg::CELL_UP1, smis_pkg::CELL_UP1};
            dload0          = (cmd.opcode == smis_pkg::OP_ADD) ? dtop1 + dtop0 : dtop1 - dtop0;
            data_count_next = data_count - DW'(1);
            pc_next         = pc + 8'd1;
          end
        end
        smis_pkg::OP_ROT: begin
          if (data_count < DW'(2)) begin
            status_next = smis_pkg::ST_DUNF;
          end else begin
            dctl_op = '{smis_pkg::CELL_LOAD, smis_pkg::CELL_LOAD, smis_pkg::CELL_HOLD};
            dload0  = dtop1;
            dload1  = dtop0;
            pc_next = pc + 8'd1;
          end
        end
        smis_pkg::OP_DUP: begin
          if (data_count == '0) begin
            status_next = smis_pkg::ST_DUNF;
          end else if (data_count == DW'(DataDepth)) begin
            status_next = smis_pkg::ST_DOVF;
          end else begin
            dctl_op         = '{smis_pkg::CELL_HOLD, smis_pkg::CELL_DOWN, smis_pkg::CELL_DOWN};
            data_count_next = data_count + DW'(1);
            pc_next         = pc + 8'd1;
          end
        end
        smis_pkg::OP_DROP: begin
          if (data_count == '0) begin
            status_next = smis_pkg::ST_DUNF;
          end else begin
            dctl_op         = CtlPop;
            data_count_next = data_count - DW'(1);
            pc_next         = pc + 8'd1;
          end
        end
        smis_pkg::OP_CALL: begin
          if (return_count == RW'(CallDepth)) begin
            status_next = smis_pkg::ST_COVF;
          end else begin
            rctl_op           = CtlPush;
            return_count_next = return_count + RW'(1);
            pc_next           = cmd.operand;
          end
        end
        smis_pkg::OP_IFNEQ: begin
          if (data_count < DW'(2)) begin
            status_next = smis_pkg::ST_DUNF;
          end else begin
            dctl_op         = '{smis_pkg::CELL_UP2, smis_pkg::CELL_UP2, smis_pkg::CELL_UP2};
            data_count_next = data_count - DW'(2);
            pc_next         = pc + 8'd2 + ((dtop0 != dtop1) ? cmd.operand : 8'd0);
          end
        end
        smis_pkg::OP_RET: begin
          if (return_count == '0) begin
            status_next = smis_pkg::ST_CUNF;
          end else begin
            rctl_op           = CtlPop;
            return_count_next = return_count - RW'(1);
            pc_next           = rtop0;
          end
        end
        smis_pkg::OP_HALT: begin
          if (data_count == '0) begin
            status_next = smis_pkg::ST_DUNF;
          end else begin
            halted_next = 1'b1;
            status_next = smis_pkg::ST_HALT;
          end
        end
        default: begin
          pc_next = pc + 8'd1;
        end
      endcase
    end
    dctl = step ? dctl_op : CtlHold;
    rctl = step ? rctl_op : CtlHold;
  end

  smis_stack #(.Width(WordBits), .Depth(DataDepth)) u_data_stack (
    .clk   (clk),
    .ctrl  (dctl),
    .load0 (dload0),
    .load1 (dload1),
    .top0  (dtop0),
    .top1  (dtop1)
  );

  smis_stack #(.Width(8), .Depth(CallDepth)) u_return_stack (
    .clk   (clk),
    .ctrl  (rctl),
    .load0 (rload0),
    .load1 (8'd0),
    .top0  (rtop0),
    .top1  ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      data_count   <= '0;
      return_count <= '0;
      pc           <= '0;
      halted       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (step) begin
        data_count   <= data_count_next;
        return_count <= return_count_next;
        pc           <= pc_next;
        halted       <= halted_next;
      end
      if (cmd_ready) begin
        res_valid <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status <= status_next;
    end
  end

  always_comb begin
    res.next_address = pc;
    res.top_value    = (data_count != '0) ? 32'($signed(dtop0)) : 32'sd0;
    res.stack_depth  = 6'(data_count);
    res.status       = status;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    data_count <= DW'(DataDepth))
    else $error("data stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> ($stable(data_count) && $stable(pc)
                                   && $stable(return_count)))
    else $error("state moved while result stalled");

  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && halted) |-> (status == smis_pkg::ST_HALT))
    else $error("halted machine reports other status");

endmodule

[tb/stack_machine_instruction_step_unit_test.sv]
`timescale 1ns / 100ps

module stack_machine_instruction_step_unit_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 950;
  localparam int unsigned DrainCycles = 8;
  localparam logic [7:0]  OpUnknownLo = 8'd10;

  class machine_tracker;
    logic [31:0] data_cells [smis_pkg::DATA_DEPTH_DEF];
    logic [7:0]  return_cells [smis_pkg::CALL_DEPTH_DEF];
    int unsigned data_count;
    int unsigned return_count;
    logic [7:0]  pc;
    bit          halted;
    smis_pkg::out_item_t pending_results [$];
    int unsigned failures;
    int unsigned results_checked;
    int unsigned status_hits [8];

    function new();
      data_count = 0;
      return_count = 0;
      pc = '0;
      halted = 1'b0;
      failures = 0;
      results_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void execute(smis_pkg::in_item_t item);
      logic [2:0]          status;
      logic [7:0]          next_pc;
      logic [31:0]         held_word;
      smis_pkg::out_item_t want;
      status = smis_pkg::ST_RUN;
      next_pc = pc;
      if (halted) begin
        status = smis_pkg::ST_HALT;
      end else begin
        case (item.opcode)
          smis_pkg::OP_PUSH: begin
            if (data_count >= smis_pkg::DATA_DEPTH_DEF) begin
              status = smis_pkg::ST_DOVF;
            end else begin
              data_cells[data_count] = {{24{item.operand[7]}}, item.operand};
              data_count++;
              next_pc = pc + 8'd2;
            end
          end
          smis_pkg::OP_ADD, smis_pkg::OP_SUB: begin
            if (data_count < 2) begin
              status = smis_pkg::ST_DUNF;
            end else begin
              if (item.opcode == smis_pkg::OP_ADD) begin
                data_cells[data_count-2] = data_cells[data_count-2] + data_cells[data_count-1];
              end else begin
                data_cells[data_count-2] = data_cells[data_count-2] - data_cells[data_count-1];
              end
              data_count--;
              next_pc = pc + 8'd1;
            end
          end
          smis_pkg::OP_ROT: begin
            if (data_count < 2) begin
              status = smis_pkg::ST_DUNF;
            end else begin
              held_word = data_cells[data_count-2];
              data_cells[data_count-2] = data_cells[data_count-1];
              data_cells[data_count-1] = held_word;
              next_pc = pc + 8'd1;
            end
          end
          smis_pkg::OP_DUP: begin
            if (data_count < 1) begin
              status = smis_pkg::ST_DUNF;
            end else if (data_count >= smis_pkg::DATA_DEPTH_DEF) begin
              status = smis_pkg::ST_DOVF;
            end else begin
              data_cells[data_count] = data_cells[data_count-1];
              data_count++;
              next_pc = pc + 8'd1;
            end
          end
          smis_pkg::OP_DROP: begin
            if (data_count < 1) begin
              status = smis_pkg::ST_DUNF;
            end else begin
              data_count--;
              next_pc = pc + 8'd1;
            end
          end
          smis_pkg::OP_CALL: begin
            if (return_count >= smis_pkg::CALL_DEPTH_DEF) begin
              status = smis_pkg::ST_COVF;
            end else begin
              return_cells[return_count] = pc + 8'd2;
              return_count++;
              next_pc = item.operand;
            end
          end
          smis_pkg::OP_IFNEQ: begin
            if (data_count < 2) begin
              status = smis_pkg::ST_DUNF;
            end else begin
              next_pc = pc + 8'd2;
              if (data_cells[data_count-1] != data_cells[data_count-2]) begin
                next_pc = next_pc + item.operand;
              end
              data_count -= 2;
            end
          end
          smis_pkg::OP_RET: begin
            if (return_count == 0) begin
              status = smis_pkg::ST_CUNF;
            end else begin
              return_count--;
              next_pc = return_cells[return_count];
            end
          end
          smis_pkg::OP_HALT: begin
            if (data_count < 1) begin
              status = smis_pkg::ST_DUNF;
            end else begin
              halted = 1'b1;
              status = smis_pkg::ST_HALT;
            end
          end
          default: begin
            next_pc = pc + 8'd1;
          end
        endcase
      end
      pc = next_pc;
      want.next_address = pc;
      want.top_value = (data_count > 0) ? data_cells[data_count-1] : '0;
      want.stack_depth = 6'(data_count);
      want.status = status;
      status_hits[status]++;
      pending_results.push_back(want);
    endfunction

    function void compare_result(smis_pkg::out_item_t got);
      smis_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: pc=%0d top=%0d depth=%0d status=%0d",
                   got.next_address, got.top_value, got.stack_depth, got.status);
        end
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.next_address !== want.next_address || got.top_value !== want.top_value ||
          got.stack_depth !== want.stack_depth || got.status !== want.status) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch on result %0d: expected pc=%0d top=%0d depth=%0d status=%0d",
                   results_checked, want.next_address, want.top_value, want.stack_depth,
                   want.status);
          $display("  actual pc=%0d top=%0d depth=%0d status=%0d",
                   got.next_address, got.top_value, got.stack_depth, got.status);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  smis_pkg::in_item_t  cmd = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  smis_pkg::out_item_t res;
  bit                  calm = 1'b0;
  int unsigned         cycle_count = 0;
  int unsigned         items_sent = 0;

  machine_tracker tracker = new();

  stack_machine_instruction_step_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) tracker.compare_result(res);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_instruction(input logic [7:0] opcode, input logic [7:0] operand);
    smis_pkg::in_item_t item;
    item.opcode = opcode;
    item.operand = operand;
    while (!calm && $urandom_range(99) < 35) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    tracker.execute(item);
    items_sent++;
  endtask

  task automatic issue_random_instruction();
    int unsigned roll;
    logic [7:0]  op;
    roll = $urandom_range(99);
    if (roll < 22) op = smis_pkg::OP_PUSH;
    else if (roll < 32) op = smis_pkg::OP_ADD;
    else if (roll < 40) op = smis_pkg::OP_SUB;
    else if (roll < 47) op = smis_pkg::OP_ROT;
    else if (roll < 55) op = smis_pkg::OP_DUP;
    else if (roll < 63) op = smis_pkg::OP_DROP;
    else if (roll < 71) op = smis_pkg::OP_CALL;
    else if (roll < 80) op = smis_pkg::OP_IFNEQ;
    else if (roll < 88) op = smis_pkg::OP_RET;
    else if (roll < 92 && tracker.data_count == 0) op = smis_pkg::OP_HALT;
    else op = 8'($urandom_range(OpUnknownLo, 255));
    send_instruction(op, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned kind;
    int unsigned run;
    int unsigned directed_count;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // refused steps on empty stacks, then a directed run of every opcode
    send_instruction(smis_pkg::OP_RET, 8'h00);
    send_instruction(smis_pkg::OP_ADD, 8'hff);
    send_instruction(smis_pkg::OP_DUP, 8'h00);
    send_instruction(smis_pkg::OP_DROP, 8'h00);
    send_instruction(smis_pkg::OP_HALT, 8'h00);
    send_instruction(smis_pkg::OP_IFNEQ, 8'h10);
    send_instruction(smis_pkg::OP_ROT, 8'h00);
    send_instruction(smis_pkg::OP_PUSH, 8'h7f);
    send_instruction(smis_pkg::OP_SUB, 8'h00);
    send_instruction(smis_pkg::OP_PUSH, 8'h80);
    send_instruction(smis_pkg::OP_PUSH, 8'hff);
    send_instruction(smis_pkg::OP_PUSH, 8'h00);
    send_instruction(smis_pkg::OP_ADD, 8'h00);
    send_instruction(smis_pkg::OP_SUB, 8'h00);
    send_instruction(smis_pkg::OP_ROT, 8'h00);
    send_instruction(smis_pkg::OP_DUP, 8'h00);
    send_instruction(smis_pkg::OP_IFNEQ, 8'h55);
    send_instruction(smis_pkg::OP_PUSH, 8'h01);
    send_instruction(smis_pkg::OP_IFNEQ, 8'hfe);
    send_instruction(smis_pkg::OP_CALL, 8'hff);
    send_instruction(smis_pkg::OP_RET, 8'h00);
    send_instruction(8'hff, 8'h00);
    send_instruction(OpUnknownLo, 8'hff);
    send_instruction(smis_pkg::OP_DROP, 8'h00);
    directed_count = items_sent;

    while (items_sent < directed_count + RandomItems) begin
      calm = (items_sent >= directed_count + 300) && (items_sent < directed_count + 450);
      kind = $urandom_range(0, 24);
      case (kind)
        0: begin
          while (tracker.data_count < smis_pkg::DATA_DEPTH_DEF) begin
            send_instruction(smis_pkg::OP_PUSH, 8'($urandom_range(255)));
          end
          send_instruction(smis_pkg::OP_PUSH, 8'($urandom_range(255)));
          send_instruction(smis_pkg::OP_DUP, 8'($urandom_range(255)));
        end
        1: begin
          while (tracker.return_count < smis_pkg::CALL_DEPTH_DEF) begin
            send_instruction(smis_pkg::OP_CALL, 8'($urandom_range(255)));
          end
          send_instruction(smis_pkg::OP_CALL, 8'($urandom_range(255)));
        end
        2: begin
          // grow the top past 32 bits so the sum wraps
          if (tracker.data_count == 0) begin
            send_instruction(smis_pkg::OP_PUSH, 8'($urandom_range(255)));
          end
          repeat (34) begin
            send_instruction(smis_pkg::OP_DUP, 8'($urandom_range(255)));
            send_instruction(smis_pkg::OP_ADD, 8'($urandom_range(255)));
          end
        end
        3: begin
          while (tracker.data_count > 0) begin
            send_instruction(smis_pkg::OP_DROP, 8'($urandom_range(255)));
          end
          send_instruction(smis_pkg::OP_ADD, 8'($urandom_range(255)));
          send_instruction(smis_pkg::OP_HALT, 8'($urandom_range(255)));
          while (tracker.return_count > 0) begin
            send_instruction(smis_pkg::OP_RET, 8'($urandom_range(255)));
          end
          send_instruction(smis_pkg::OP_RET, 8'($urandom_range(255)));
        end
        default: begin
          run = $urandom_range(1, 8);
          repeat (run) issue_random_instruction();
        end
      endcase
    end
    calm = 1'b0;

    // halt for real, then confirm the machine holds
    if (tracker.data_count == 0) send_instruction(smis_pkg::OP_PUSH, 8'($urandom_range(255)));
    send_instruction(smis_pkg::OP_HALT, 8'($urandom_range(255)));
    send_instruction(smis_pkg::OP_PUSH, 8'($urandom_range(255)));
    send_instruction(smis_pkg::OP_CALL, 8'($urandom_range(255)));
    send_instruction(smis_pkg::OP_RET, 8'($urandom_range(255)));
    send_instruction(8'hc3, 8'($urandom_range(255)));
    send_instruction(smis_pkg::OP_HALT, 8'($urandom_range(255)));
    cmd_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d instructions, %0d results checked, %0d failures",
             items_sent, tracker.results_checked, tracker.failures);
    $display("Outcomes: run %0d, halt %0d, data ovf %0d, data unf %0d, call ovf %0d, %s %0d",
             tracker.status_hits[smis_pkg::ST_RUN], tracker.status_hits[smis_pkg::ST_HALT],
             tracker.status_hits[smis_pkg::ST_DOVF], tracker.status_hits[smis_pkg::ST_DUNF],
             tracker.status_hits[smis_pkg::ST_COVF], "call unf",
             tracker.status_hits[smis_pkg::ST_CUNF]);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/smis_pkg.sv
rtl/smis_cell.sv
rtl/smis_stack.sv
rtl/stack_machine_instruction_step_unit.sv
tb/stack_machine_instruction_step_unit_test.sv
